@@ design/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types, constants and helpers for the sorted insert table.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int KEY_W        = 64;
	localparam int QTY_W        = 16;
	localparam int PRICE_W      = 24;
	localparam int POS_W        = 7;
	localparam int TOTAL_W      = 7;
	localparam int STATUS_W     = 2;
	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BYTES    = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic [KEY_W-1:0]   name_key;
		logic [QTY_W-1:0]   quantity;
		logic [PRICE_W-1:0] price_cents;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    entry_key;
		logic [QTY_W-1:0]    entry_quantity;
		logic [PRICE_W-1:0]  entry_price;
		logic [TOTAL_W-1:0]  stored_total;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [QTY_W-1:0]   qty;
		logic [PRICE_W-1:0] price;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic occupied;
		logic prev_ge;
		logic sel;
	} cell_ctl_t;

	// Only the leading KEY_BYTES bytes of a key take part.
	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
		({KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES));

endpackage

@@ design/sorted_insert_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_table_core
// Sorted table built as a row of cells; insert in key order, read by position.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after a request is accepted.
// Throughput: one request per cycle unless the response is stalled; each insert
// compares and shifts in every cell at once, a read selects one cell.
// Reset: arst_n clears the fill count and response valid; cell contents are
// left undefined and are never read before written.
module sorted_insert_table_core #(
	parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sit_pkg::rsp_t rsp
);
	import sit_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

	logic [FILL_W-1:0] fill_q, fill_next;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic   accept, full, do_ins, bad_pos;
	logic   [CMP_W-1:0] pos_ext;
	entry_t new_entry, rd_data;
	entry_t cell_entry [CAPACITY];
	entry_t cell_rd    [CAPACITY];
	logic   [CAPACITY-1:0] cell_ge;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (fill_q == FILL_W'(CAPACITY));
	assign do_ins    = accept && (req.cmd == CMD_INSERT) && !full;
	assign pos_ext   = CMP_W'(req.position);
	assign bad_pos   = (pos_ext == '0) || (pos_ext > CMP_W'(fill_q));
	assign fill_next = do_ins ? fill_q + 1'b1 : fill_q;

	assign new_entry.key   = req.name_key & KEY_MASK;
	assign new_entry.qty   = req.quantity;
	assign new_entry.price = req.price_cents;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.ins      = do_ins;
		assign ctl.occupied = FILL_W'(i) < fill_q;
		assign ctl.prev_ge  = (i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i - 1];
		assign ctl.sel      = (pos_ext == CMP_W'(i + 1));

		sit_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
			.ge         (cell_ge[i]),
			.entry      (cell_entry[i]),
			.rd_entry   (cell_rd[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.stored_total <= TOTAL_W'(fill_next);
			if (req.cmd == CMD_INSERT) begin
				rsp_q.status         <= full ? ST_FULL : ST_OK;
				rsp_q.entry_key      <= '0;
				rsp_q.entry_quantity <= '0;
				rsp_q.entry_price    <= '0;
			end else if (bad_pos) begin
				rsp_q.status         <= ST_BAD_POS;
				rsp_q.entry_key      <= '0;
				rsp_q.entry_quantity <= '0;
				rsp_q.entry_price    <= '0;
			end else begin
				rsp_q.status         <= ST_OK;
				rsp_q.entry_key      <= rd_data.key;
				rsp_q.entry_quantity <= rd_data.qty;
				rsp_q.entry_price    <= rd_data.price;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("fill count above capacity");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert did not advance fill count");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_ins |=> $stable(fill_q))
		else $error("fill count moved without insert");

	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == CMD_INSERT |=> rsp_q.entry_key == '0)
		else $error("insert response carries a key");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.entry_key == '0)
		else $error("failed request carries a key");

endmodule

@@ design/sit_cell.sv @@
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: compares against the broadcast key, shifts up on insert.
// ----------------------------------------------------------------------------
module sit_cell (
	input  logic             clk,
	input  sit_pkg::cell_ctl_t ctl,
	input  sit_pkg::entry_t  new_entry,
	input  sit_pkg::entry_t  prev_entry,
	output logic             ge,
	output sit_pkg::entry_t  entry,
	output sit_pkg::entry_t  rd_entry
);
	import sit_pkg::*;

	entry_t entry_q;

	// empty slots and keys not below the new key take part in the shift
	assign ge       = !ctl.occupied || (entry_q.key >= new_entry.key);
	assign entry    = entry_q;
	assign rd_entry = ctl.sel ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.prev_ge) begin
				entry_q <= prev_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule
